// File: rtl/core/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // apply the operation to indices, count and store
    logic read;   // fetch front and back words
  } deq_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/deq_in_if.sv
`default_nettype none

interface deq_in_if
  import deq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic        [FUNC_W-1:0]  func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/deq_out_if.sv
`default_nettype none

interface deq_out_if
  import deq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] front_word;
  logic signed [VALUE_W-1:0] back_word;
  logic        [COUNT_W-1:0] entry_count;
  logic                      is_empty;
  logic                      overflow;
  logic                      underflow;

  modport source (
    output valid, output front_word, output back_word, output entry_count,
    output is_empty, output overflow, output underflow, input ready
  );
  modport sink (
    input valid, input front_word, input back_word, input entry_count,
    input is_empty, input overflow, input underflow, output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/deq_ctrl.sv
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output deq_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_READ;
      ST_READ: state_next = ST_OUT;
      ST_OUT: begin
        if (rsp_ready) state_next = req_valid ? ST_EXEC : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_OUT: begin
        rsp_valid = 1'b1;
        // next item may enter as the current result leaves
        req_ready = rsp_ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
    cmd.load = req_valid && req_ready;
  end

endmodule

`default_nettype wire

// File: rtl/core/deq_datapath.sv
`default_nettype none

module deq_datapath
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire deq_cmd_t                  cmd,
  input  wire logic        [FUNC_W-1:0]  func,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic signed      [VALUE_W-1:0] front_word,
  output logic signed      [VALUE_W-1:0] back_word,
  output logic             [COUNT_W-1:0] entry_count,
  output logic                           is_empty,
  output logic                           overflow,
  output logic                           underflow
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - 1'b1;
  endfunction

  logic signed [WORD_WIDTH-1:0] mem [DEPTH];

  op_t                          func_q;
  logic        [WORD_WIDTH-1:0] word_q;
  logic        [IDX_W-1:0]      head;
  logic        [IDX_W-1:0]      tail;
  logic        [CNT_W-1:0]      count;
  logic signed [WORD_WIDTH-1:0] front_q;
  logic signed [WORD_WIDTH-1:0] back_q;
  logic                         ovf_q;
  logic                         unf_q;

  logic                         full;
  logic                         empty;
  logic                         mem_we;
  logic        [IDX_W-1:0]      mem_waddr;
  logic        [IDX_W-1:0]      head_next;
  logic        [IDX_W-1:0]      tail_next;
  logic        [CNT_W-1:0]      count_next;
  logic                         ovf_next;
  logic                         unf_next;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = tail;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ovf_next   = 1'b0;
    unf_next   = 1'b0;
    case (func_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          ovf_next = 1'b1;
        end else begin
          head_next  = idx_prev(head);
          mem_we     = 1'b1;
          mem_waddr  = idx_prev(head);
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          ovf_next = 1'b1;
        end else begin
          tail_next  = idx_next(tail);
          mem_we     = 1'b1;
          mem_waddr  = tail;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          unf_next = 1'b1;
        end else begin
          head_next  = idx_next(head);
          count_next = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          unf_next = 1'b1;
        end else begin
          tail_next  = idx_prev(tail);
          count_next = count - 1'b1;
        end
      end
      default: begin
        ovf_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= op_t'(func);
      word_q <= WORD_WIDTH'($unsigned(value));
    end
    if (cmd.exec) begin
      ovf_q <= ovf_next;
      unf_q <= unf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[mem_waddr] <= word_q;
    end
  end

  // two read ports: front at head, back one below tail
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      front_q <= mem[head];
      back_q  <= mem[idx_prev(tail)];
    end
  end

  assign is_empty    = empty;
  assign front_word  = empty ? '0 : VALUE_W'(front_q);
  assign back_word   = empty ? '0 : VALUE_W'(back_q);
  assign entry_count = COUNT_W'(count);
  assign overflow    = ovf_q;
  assign underflow   = unf_q;

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue_unit.sv
// Double-ended queue of signed words held in a ring buffer.
// req channel: func (0 push front, 1 push back, 2 pop front, 3 pop back)
// and value, the word to push (ignored for pops).
// rsp channel: one item per request with the front and back words, the
// entry count and empty flag after the operation, plus overflow (push
// dropped because the queue was full) and underflow (pop on empty queue).
// Front and back read 0 while the queue is empty.
// Each request goes through the states EXEC (move the indices and write
// the store), READ (the registered two-port read of front and back) and
// OUT (present the result); a new request is taken in the same cycle the
// current result is taken, so requests do not overlap.
// Reset (synchronous, rst high) empties the queue: head, tail and count
// clear; the word store is not cleared and needs no clearing pass.
// When the receiver holds rsp.ready low the result stays valid and stable
// and no new request is accepted until it is taken.
`default_nettype none

module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  deq_in_if.sink    req,
  deq_out_if.source rsp
);

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (req.func),
    .value       (req.value),
    .front_word  (rsp.front_word),
    .back_word   (rsp.back_word),
    .entry_count (rsp.entry_count),
    .is_empty    (rsp.is_empty),
    .overflow    (rsp.overflow),
    .underflow   (rsp.underflow)
  );

endmodule

`default_nettype wire

// File: rtl/core/deq_checker.sv
`default_nettype none

module deq_checker
  import deq_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [VALUE_W-1:0] front_word,
  input wire logic [VALUE_W-1:0] back_word,
  input wire logic [COUNT_W-1:0] entry_count,
  input wire logic               is_empty,
  input wire logic               overflow,
  input wire logic               underflow
);

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && is_empty) |-> (front_word == '0 && back_word == '0))
    else $error("empty queue shows nonzero front or back");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(overflow && underflow) && !(overflow && is_empty)
                  && !(underflow && !is_empty))
    else $error("overflow/underflow inconsistent with queue state");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(entry_count)
                                  && $stable(front_word) && $stable(back_word)))
    else $error("stalled result changed");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .front_word  (rsp.front_word),
  .back_word   (rsp.back_word),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty),
  .overflow    (rsp.overflow),
  .underflow   (rsp.underflow)
);

`default_nettype wire

// File: tb/double_ended_queue_unit_tb.sv
`default_nettype none

module double_ended_queue_unit_tb;
  import deq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int N_ITEMS    = 1700;
  localparam int LONG_HOLD  = 150;
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] front_word;
    logic signed [VALUE_W-1:0] back_word;
    logic        [COUNT_W-1:0] entry_count;
    logic                      is_empty;
    logic                      overflow;
    logic                      underflow;
  } deq_state_t;

  // Mirror of the ring buffer plus the states it still expects to see.
  class deque_mirror;
    logic signed [VALUE_W-1:0] words [DEPTH];
    int head, tail, held;
    deq_state_t awaited_states[$];
    int errors, n_push, n_pop, n_dropped, n_underflow, n_full;

    function new();
      head = 0;
      tail = 0;
      held = 0;
      errors = 0;
      n_push = 0;
      n_pop = 0;
      n_dropped = 0;
      n_underflow = 0;
      n_full = 0;
    endfunction

    function int pending();
      return awaited_states.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
    endtask

    function void note_op(op_t op, logic signed [VALUE_W-1:0] val);
      deq_state_t s;
      s = '0;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
        n_push++;
        if (held >= DEPTH) begin
          s.overflow = 1'b1;
          n_dropped++;
        end else if (op == OP_PUSH_FRONT) begin
          head = (head + DEPTH - 1) % DEPTH;
          words[head] = val;
          held++;
        end else begin
          words[tail] = val;
          tail = (tail + 1) % DEPTH;
          held++;
        end
        if (held == DEPTH && !s.overflow) n_full++;
      end else begin
        n_pop++;
        if (held == 0) begin
          s.underflow = 1'b1;
          n_underflow++;
        end else if (op == OP_POP_FRONT) begin
          head = (head + 1) % DEPTH;
          held--;
        end else begin
          tail = (tail + DEPTH - 1) % DEPTH;
          held--;
        end
      end
      if (held != 0) begin
        s.front_word = words[head];
        s.back_word  = words[(tail + DEPTH - 1) % DEPTH];
      end
      s.entry_count = COUNT_W'(held);
      s.is_empty    = (held == 0);
      awaited_states.insert(awaited_states.size(), s);
    endfunction

    task check_state(deq_state_t got);
      deq_state_t exp;
      if (awaited_states.size() == 0) begin
        report("result item with no operation outstanding");
        return;
      end
      exp = awaited_states[0];
      awaited_states.delete(0);
      if (got.front_word !== exp.front_word)
        report($sformatf("front_word %0d, expected %0d", got.front_word, exp.front_word));
      if (got.back_word !== exp.back_word)
        report($sformatf("back_word %0d, expected %0d", got.back_word, exp.back_word));
      if (got.entry_count !== exp.entry_count)
        report($sformatf("entry_count %0d, expected %0d", got.entry_count, exp.entry_count));
      if (got.is_empty !== exp.is_empty)
        report($sformatf("is_empty %b, expected %b", got.is_empty, exp.is_empty));
      if (got.overflow !== exp.overflow)
        report($sformatf("overflow %b, expected %b", got.overflow, exp.overflow));
      if (got.underflow !== exp.underflow)
        report($sformatf("underflow %b, expected %b", got.underflow, exp.underflow));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  deq_in_if  req_if ();
  deq_out_if rsp_if ();

  double_ended_queue_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  deque_mirror mirror;
  bit tx_idle, rx_idle, long_hold_req;
  int n_sent;

  initial begin
    mirror = new();
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.func  = OP_PUSH_FRONT;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    long_hold_req = 1'b0;
    n_sent = 0;
  end

  task automatic send_op(op_t op, logic signed [VALUE_W-1:0] val);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.func  = op;
    req_if.value = val;
    do @(posedge clk); while (!req_if.ready);
    mirror.note_op(op, val);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t rand_op(int bias);
    int push_pct;
    bit push;
    push_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
    push = ($urandom_range(1, 100) <= push_pct);
    if (push) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // Result side: random stall before each item, one long hold on request.
  initial begin
    deq_state_t got;
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (long_hold_req) begin
        gap = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (gap != 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      got.front_word  = rsp_if.front_word;
      got.back_word   = rsp_if.back_word;
      got.entry_count = rsp_if.entry_count;
      got.is_empty    = rsp_if.is_empty;
      got.overflow    = rsp_if.overflow;
      got.underflow   = rsp_if.underflow;
      mirror.check_state(got);
      @(negedge clk);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, mirror.pending());
    $display("double_ended_queue_unit_tb NOT OK");
    $finish;
  end

  initial begin
    int phase, bias, len;
    phase = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty pops, extreme words at both ends, drain to empty
    send_op(OP_POP_FRONT, 32'sh12345678);
    send_op(OP_POP_BACK, -1);
    send_op(OP_PUSH_BACK, 32'sh7fffffff);
    send_op(OP_PUSH_FRONT, 32'sh80000000);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_FRONT, -1);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PUSH_FRONT, 32'sd1);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PUSH_BACK, 32'sh55555555);
    send_op(OP_PUSH_FRONT, 32'shaaaaaaaa);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    wait_drained();

    // random: phases that lean toward filling, draining or neither
    while (n_sent < N_ITEMS) begin
      phase++;
      bias = $urandom_range(0, 2);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      len = $urandom_range(16, 64);
      if (phase == 3) begin
        tx_idle = 1'b0;
        long_hold_req = 1'b1;
      end
      repeat (len) send_op(rand_op(bias), rand_word());
      if (phase == 5 || $urandom_range(0, 3) == 0) wait_drained();
    end
    req_if.valid = 1'b0;

    while (mirror.pending() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d operations: %0d pushes (%0d dropped on full), %0d pops (%0d on empty)",
             n_sent, mirror.n_push, mirror.n_dropped, mirror.n_pop, mirror.n_underflow);
    $display("queue reached full %0d times over %0d phases", mirror.n_full, phase);
    if (mirror.errors == 0) begin
      $display("double_ended_queue_unit_tb OK");
    end else begin
      $display("double_ended_queue_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
